>>> rtl/sbps_pkg.sv
// Shared types and constants for the sort-based permutation sampler.
// Has no dependencies. The cell and the top level import it.
package sbps_pkg;

	localparam int KEY_W    = 32;
	localparam int IDX_BITS = 11;
	localparam int RND_W    = 21;

	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [RND_W-1:0]    rnd_t;
	typedef logic [IDX_BITS-1:0] idx_t;

	// Per-cycle command to every cell of the chain
	typedef struct packed {
		logic ins;    // insert the broadcast key into the sorted row
		logic shift;  // move each key one cell toward the head
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_DRAIN = 3'b010,
		ST_FAIL  = 3'b100
	} state_t;

endpackage

>>> rtl/sbps_cell.sv
// One cell of the insertion-sort chain: holds one key and trades with its neighbors.
// Depends on sbps_pkg.
module sbps_cell (
	input  logic              clk,
	input  sbps_pkg::cell_ctl_t ctl,
	input  sbps_pkg::key_t    new_key,
	input  logic              occupied,
	input  logic              prev_gt,
	input  sbps_pkg::key_t    prev_key,
	input  sbps_pkg::key_t    next_key,
	output sbps_pkg::key_t    key,
	output logic              gt,
	output logic              hit
);
	import sbps_pkg::*;

	key_t key_q;

	// An empty cell counts as larger than any key
	assign gt  = !occupied || (key_q > new_key);
	assign hit = occupied && (key_q[KEY_W-1:IDX_BITS] == new_key[KEY_W-1:IDX_BITS]);
	assign key = key_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (gt) begin
				key_q <= prev_gt ? prev_key : new_key;
			end
		end else if (ctl.shift) begin
			key_q <= next_key;
		end
	end

endmodule

>>> rtl/sort_based_permutation_sampler.sv
// Sort-based permutation sampler: top level with control and the cell chain.
// Depends on sbps_pkg and sbps_cell.
//
// The block collects PERM_SIZE random words, one per beat on the rnd channel,
// keeps the low 21 bits of each and tags it with its arrival index. Every word
// is placed into a row of PERM_SIZE cells that always stays sorted ascending:
// in the cycle a word is taken, each cell from the insertion point up hands its
// key to the next cell up, so each word is sorted in as it is taken. After the
// last word of a batch the row unloads through its head cell, one beat per cycle
// on the perm channel while perm_stall is low, giving the arrival indices in
// sorted order with last_entry on the final beat. If any two words of the batch
// shared a random part, the batch instead yields one beat with collision and
// last_entry set. All results leave through the single head cell. No words are
// taken while a batch unloads. Key storage needs no clearing after reset; the
// fill count alone tells which cells hold live keys.
module sort_based_permutation_sampler #(
	parameter int PERM_SIZE = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 rnd_valid,
	output logic                 rnd_stall,
	input  sbps_pkg::rnd_t       random_value,
	output logic                 perm_valid,
	input  logic                 perm_stall,
	output sbps_pkg::idx_t       perm_entry,
	output logic                 last_entry,
	output logic                 collision
);
	import sbps_pkg::*;

	localparam int CNT_W = $clog2(PERM_SIZE + 1);
	localparam logic [CNT_W-1:0] LAST_LOAD = CNT_W'(PERM_SIZE - 1);
	localparam logic [CNT_W-1:0] ONE       = CNT_W'(1);

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;     // words loaded, then beats left to send
	logic              dup_q;

	logic              rnd_beat;
	logic              perm_beat;
	logic              dup_now;
	key_t              new_key;
	cell_ctl_t         ctl;

	key_t              key_arr [PERM_SIZE];
	logic [PERM_SIZE-1:0] gt_vec;
	logic [PERM_SIZE-1:0] hit_vec;

	assign rnd_stall  = (state_q != ST_LOAD);
	assign rnd_beat   = rnd_valid && !rnd_stall;
	assign perm_valid = (state_q == ST_DRAIN) || (state_q == ST_FAIL);
	assign perm_beat  = perm_valid && !perm_stall;

	// Key: random part above, arrival index below
	assign new_key = {random_value, IDX_BITS'(cnt_q)};

	assign ctl.ins   = rnd_beat;
	assign ctl.shift = perm_beat && (state_q == ST_DRAIN);

	// Any live key sharing the random part marks the batch as failed
	assign dup_now = dup_q || (|hit_vec);

	// Head cell feeds the output; a failure beat carries index zero
	assign perm_entry = (state_q == ST_DRAIN) ? key_arr[0][IDX_BITS-1:0] : '0;
	assign last_entry = (state_q == ST_FAIL) || (cnt_q == ONE);
	assign collision  = (state_q == ST_FAIL);

	for (genvar i = 0; i < PERM_SIZE; i++) begin : g_cell
		localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(i);
		logic  occ;
		logic  prev_gt;
		key_t  prev_key;
		key_t  next_key;

		assign occ = (CELL_IDX < cnt_q);

		if (i == 0) begin : g_head
			assign prev_gt  = 1'b0;
			assign prev_key = '0;
		end else begin : g_body
			assign prev_gt  = gt_vec[i-1];
			assign prev_key = key_arr[i-1];
		end

		if (i == PERM_SIZE - 1) begin : g_tail
			assign next_key = '0;
		end else begin : g_inner
			assign next_key = key_arr[i+1];
		end

		sbps_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.new_key  (new_key),
			.occupied (occ),
			.prev_gt  (prev_gt),
			.prev_key (prev_key),
			.next_key (next_key),
			.key      (key_arr[i]),
			.gt       (gt_vec[i]),
			.hit      (hit_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			dup_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (rnd_beat) begin
						cnt_q <= cnt_q + ONE;
						dup_q <= dup_now;
						// Batch full: send the result or the failure beat
						if (cnt_q == LAST_LOAD) begin
							state_q <= dup_now ? ST_FAIL : ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (perm_beat) begin
						cnt_q <= cnt_q - ONE;
						if (cnt_q == ONE) begin
							state_q <= ST_LOAD;
							dup_q   <= 1'b0;
						end
					end
				end
				ST_FAIL: begin
					if (perm_beat) begin
						state_q <= ST_LOAD;
						cnt_q   <= '0;
						dup_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
					cnt_q   <= '0;
					dup_q   <= 1'b0;
				end
			endcase
		end
	end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// Testbench for sort_based_permutation_sampler: random-word batches in, permutation beats out.
// Depends on sbps_pkg and the sampler RTL; a scoreboard class predicts each batch's beats.
module testbench;
	import sbps_pkg::*;

	localparam int PERM_SIZE = 64;
	localparam int NUM_BATCHES = 6;
	localparam rnd_t RND_MAX = '1;
	// Longest legal stretch with no beat accepted is a long gap plus a long stall plus
	// a drain start; this allows many times that.
	localparam int WATCHDOG_LIMIT = 4000;

	// One permutation beat as the block should present it
	typedef struct packed {
		idx_t entry;
		logic last;
		logic coll;
	} perm_beat_t;

	// Content patterns for one batch of words
	typedef enum {
		BATCH_DIRECTED_OK,
		BATCH_DIRECTED_DUP,
		BATCH_UNIQUE,
		BATCH_DUP,
		BATCH_DESCEND,
		BATCH_NARROW,
		BATCH_SAME
	} batch_kind_t;

	// Collect each batch, sort its tagged keys and queue the beats it must yield
	class perm_scoreboard;
		int unsigned size;
		int unsigned errors;
		rnd_t batch_words[$];
		perm_beat_t expected_beats[$];

		function new(int unsigned perm_size);
			size   = perm_size;
			errors = 0;
		endfunction

		function int unsigned pending();
			return expected_beats.size();
		endfunction

		function void note_word(rnd_t word);
			key_t keys[$];
			perm_beat_t beat;
			bit dup;
			int i;
			batch_words.push_back(word);
			if (batch_words.size() < size)
				return;
			for (i = 0; i < batch_words.size(); i++)
				keys.push_back({batch_words[i], idx_t'(i)});
			keys.sort();
			dup = 1'b0;
			for (i = 1; i < keys.size(); i++)
				if (keys[i][KEY_W-1:IDX_BITS] == keys[i-1][KEY_W-1:IDX_BITS])
					dup = 1'b1;
			if (dup) begin
				beat.entry = '0;
				beat.last  = 1'b1;
				beat.coll  = 1'b1;
				expected_beats.push_back(beat);
			end else begin
				for (i = 0; i < keys.size(); i++) begin
					beat.entry = keys[i][IDX_BITS-1:0];
					beat.last  = (i == keys.size() - 1);
					beat.coll  = 1'b0;
					expected_beats.push_back(beat);
				end
			end
			batch_words.delete();
		endfunction

		function void check_beat(idx_t entry, logic last, logic coll);
			perm_beat_t want;
			if (expected_beats.size() == 0) begin
				$error("unexpected beat: perm_entry %0d last_entry %0b collision %0b",
					entry, last, coll);
				errors++;
				return;
			end
			want = expected_beats.pop_front();
			if (entry !== want.entry) begin
				$error("perm_entry: expected %0d, actual %0d", want.entry, entry);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_entry: expected %0b, actual %0b", want.last, last);
				errors++;
			end
			if (coll !== want.coll) begin
				$error("collision: expected %0b, actual %0b", want.coll, coll);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic rnd_valid;
	logic rnd_stall;
	rnd_t random_value;
	logic perm_valid;
	logic perm_stall;
	idx_t perm_entry;
	logic last_entry;
	logic collision;

	perm_scoreboard sb;
	rnd_t batch_buf [PERM_SIZE];
	bit tx_calm;
	bit rx_calm;
	int idle_cycles;

	sort_based_permutation_sampler #(
		.PERM_SIZE(PERM_SIZE)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.rnd_valid   (rnd_valid),
		.rnd_stall   (rnd_stall),
		.random_value(random_value),
		.perm_valid  (perm_valid),
		.perm_stall  (perm_stall),
		.perm_entry  (perm_entry),
		.last_entry  (last_entry),
		.collision   (collision)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly short pauses, now and then a long one
	function automatic int pause_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int word_gap();
		if (tx_calm || $urandom_range(0, 99) < 60)
			return 0;
		return pause_len();
	endfunction

	// Weight toward clean batches so most runs reach the drain phase
	function automatic batch_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return BATCH_UNIQUE;
		if (r < 70)
			return BATCH_DUP;
		if (r < 80)
			return BATCH_DESCEND;
		if (r < 90)
			return BATCH_NARROW;
		return BATCH_SAME;
	endfunction

	// Fill batch_buf with one batch of words of the given pattern
	task automatic fill_batch(input batch_kind_t kind);
		int i;
		int j;
		int step;
		rnd_t same_word;
		step      = $urandom_range(1, 30000);
		same_word = rnd_t'($urandom);
		for (i = 0; i < PERM_SIZE; i++)
			batch_buf[i] = rnd_t'($urandom);
		case (kind)
			BATCH_DIRECTED_OK, BATCH_DIRECTED_DUP: begin
				// Lead with both extremes and a walking one across every bit
				batch_buf[0] = '0;
				batch_buf[1] = RND_MAX;
				for (i = 0; i < RND_W && i + 2 < PERM_SIZE; i++)
					batch_buf[i+2] = rnd_t'(1) << i;
				// Repeat the top value on the final word: the clash shows up on the
				// very insert that completes the batch
				if (kind == BATCH_DIRECTED_DUP)
					batch_buf[PERM_SIZE-1] = RND_MAX;
			end
			BATCH_DUP: begin
				i = $urandom_range(0, PERM_SIZE - 2);
				j = $urandom_range(i + 1, PERM_SIZE - 1);
				batch_buf[j] = batch_buf[i];
			end
			BATCH_DESCEND: begin
				// Every word lands at the head of the row
				for (i = 0; i < PERM_SIZE; i++)
					batch_buf[i] = RND_MAX - rnd_t'(i * step);
			end
			BATCH_NARROW: begin
				for (i = 0; i < PERM_SIZE; i++)
					batch_buf[i] = rnd_t'($urandom_range(0, PERM_SIZE * 4));
			end
			BATCH_SAME: begin
				for (i = 0; i < PERM_SIZE; i++)
					batch_buf[i] = same_word;
			end
			default: ;
		endcase
	endtask

	// Present one word after an optional gap; hold it until the beat is taken
	task automatic send_word(input rnd_t word, input int gap);
		if (gap > 0) begin
			rnd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rnd_valid    <= 1'b1;
		random_value <= word;
		do @(posedge clk); while (rnd_stall);
		sb.note_word(word);
		@(negedge clk);
	endtask

	// Drop valid and hold off until every queued beat has come out
	task automatic wait_drained();
		rnd_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	// Receiver: stall in bursts of random length, except in calm phases
	initial begin
		int hold;
		hold = 0;
		perm_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				perm_stall <= 1'b1;
				hold--;
			end else begin
				perm_stall <= 1'b0;
				if (!rx_calm && $urandom_range(0, 99) < 25)
					hold = pause_len();
			end
		end
	end

	// Check every accepted permutation beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && perm_valid && !perm_stall)
			sb.check_beat(perm_entry, last_entry, collision);
	end

	// Watchdog: end the run if no beat moves on either channel for too long
	always @(posedge clk) begin
		if ((rnd_valid && !rnd_stall) || (perm_valid && !perm_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL sort_based_permutation_sampler");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int b;
		int i;
		batch_kind_t kind;
		sb           = new(PERM_SIZE);
		tx_calm      = 1'b0;
		rx_calm      = 1'b0;
		arst_n       = 1'b0;
		rnd_valid    = 1'b0;
		random_value = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First two batches are directed: extremes and walking ones, once clean and
		// once with a clash on the last word. The rest are random patterns.
		for (b = 0; b < NUM_BATCHES; b++) begin
			if (b == 0)
				kind = BATCH_DIRECTED_OK;
			else if (b == 1)
				kind = BATCH_DIRECTED_DUP;
			else
				kind = pick_kind();
			fill_batch(kind);
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			// Let the pipeline empty completely once before starting a batch
			if (b == 3)
				wait_drained();
			for (i = 0; i < PERM_SIZE; i++)
				send_word(batch_buf[i], word_gap());
		end
		rnd_valid <= 1'b0;

		// Wait for the last beats, then watch a while longer for stray ones
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (2 * PERM_SIZE + 16) @(negedge clk);

		if (sb.errors == 0)
			$display("PASS sort_based_permutation_sampler");
		else
			$display("FAIL sort_based_permutation_sampler");
		$finish;
	end

endmodule

>>> filelist.f
rtl/sbps_pkg.sv
rtl/sbps_cell.sv
rtl/sort_based_permutation_sampler.sv
test/testbench.sv
